### sv/bbsa_pkg.sv
// Shared types and constants of the bitmap block store allocator.
package bbsa_pkg;

    localparam int MAX_BLOCKS      = 1024;
    localparam int MAX_BLOCK_BYTES = 64;
    localparam int POINTER_BYTES   = 4;

    localparam int MAP_ROW_BITS = 32;
    localparam int MAP_ROWS     = MAX_BLOCKS / MAP_ROW_BITS;
    localparam int MAP_AW       = $clog2(MAP_ROWS);
    localparam int MAP_BW       = $clog2(MAP_ROW_BITS);

    localparam int WORD_BYTES  = POINTER_BYTES;
    localparam int WORD_W      = 8 * WORD_BYTES;
    localparam int WPB         = MAX_BLOCK_BYTES / WORD_BYTES;
    localparam int WOFF_W      = $clog2(WPB);
    localparam int LANE_W      = $clog2(WORD_BYTES);
    localparam int STORE_WORDS = MAX_BLOCKS * WPB;

    localparam int CMD_W  = 2;
    localparam int BLK_W  = 10;
    localparam int OFF_W  = 6;
    localparam int LEN_W  = 16;
    localparam int PIX_W  = 4;
    localparam int CNT_W  = 11;
    localparam int SIZE_W = 7;
    localparam int CFG_W  = 11;
    localparam int STAT_W = 2;
    localparam int VAL_W  = 32;
    localparam int NW_W   = SIZE_W - LANE_W;

    localparam int STORE_AW = BLK_W + WOFF_W;

    localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = CNT_W'(1024);
    localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = SIZE_W'(64);

    localparam logic CFG_BLOCK_COUNT = 1'b0;
    localparam logic CFG_BLOCK_SIZE  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_PTR   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NONE_FREE = 2'd1,
        STAT_TOO_LONG  = 2'd2,
        STAT_RANGE     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_FREE_WR,
        S_ZERO,
        S_PTR_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    we;
        logic [MAP_AW-1:0]       waddr;
        logic [MAP_ROW_BITS-1:0] wdata;
        logic                    re;
        logic [MAP_AW-1:0]       raddr;
    } t_map_req;

    typedef struct packed {
        logic                  we;
        logic [WORD_BYTES-1:0] be;
        logic [STORE_AW-1:0]   waddr;
        logic [WORD_W-1:0]     wdata;
        logic                  re;
        logic [STORE_AW-1:0]   raddr;
    } t_store_req;

endpackage

### sv/bitmap_block_store_allocator_top.sv
// Top level of the bitmap block store allocator.
//
// Input channel: i_in_valid / o_in_stall carry one command word (cmd, block number,
// byte offset, data byte, text length, pointer index). Output channel:
// o_out_valid / i_out_stall carry one status and result value per command.
// Configuration: i_cfg_we writes block_count (index 0) or block_size (index 1)
// from i_cfg_data at once; write only while the block is idle.
// One command is worked at a time; o_in_stall is high while it runs.
// Work per command, from acceptance to result in the output register:
//   allocate      scans bitmap rows of 32 blocks until a free block is found
//   free          zeroes ceil(block_size / 4) store words
//   write byte    one byte lane written;  read pointer one word read from the byte store
// Allocation rate is set by the bitmap row read and scan loop; free by the
// single store write port. Range failures go straight to the result.
// Reset starts a clearing pass that zeroes the byte store and
// the bitmap; o_in_stall stays high meanwhile, configuration writes are taken.
// A stalled result holds in the output register; the next command is still
// accepted and its result waits until the output register is free.
module bitmap_block_store_allocator_top import bbsa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [BLK_W-1:0]   i_block_number,
    input  logic [OFF_W-1:0]   i_byte_offset,
    input  logic [7:0]         i_data_byte,
    input  logic [LEN_W-1:0]   i_text_length,
    input  logic [PIX_W-1:0]   i_pointer_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [VAL_W-1:0]   o_result_value
);

    t_map_req                map_req;
    logic [MAP_ROW_BITS-1:0] map_rdata;
    t_store_req              store_req;
    logic [WORD_W-1:0]       store_rdata;

    bbsa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_block_number (i_block_number),
        .i_byte_offset  (i_byte_offset),
        .i_data_byte    (i_data_byte),
        .i_text_length  (i_text_length),
        .i_pointer_index(i_pointer_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_map_req      (map_req),
        .i_map_rdata    (map_rdata),
        .o_store_req    (store_req),
        .i_store_rdata  (store_rdata)
    );

    bbsa_map_ram u_map (
        .i_clk  (i_clk),
        .i_req  (map_req),
        .o_rdata(map_rdata)
    );

    bbsa_store_ram u_store (
        .i_clk  (i_clk),
        .i_req  (store_req),
        .o_rdata(store_rdata)
    );

endmodule

### sv/bbsa_map_ram.sv
// Used-block bitmap memory, one row of block flags per word.
module bbsa_map_ram import bbsa_pkg::*; (
    input  logic                    i_clk,
    input  t_map_req                i_req,
    output logic [MAP_ROW_BITS-1:0] o_rdata
);

    logic [MAP_ROW_BITS-1:0] r_mem [MAP_ROWS];
    logic [MAP_ROW_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bbsa_store_ram.sv
// Block byte store memory, one pointer-sized word per entry with byte enables.
module bbsa_store_ram import bbsa_pkg::*; (
    input  logic              i_clk,
    input  t_store_req        i_req,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [STORE_WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            for (int j = 0; j < WORD_BYTES; j++) begin
                if (i_req.be[j]) begin
                    r_mem[i_req.waddr][8*j +: 8] <= i_req.wdata[8*j +: 8];
                end
            end
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bbsa_ctrl.sv
// Sequencer with configuration, bitmap scan unit, clearing pass and result register.
module bbsa_ctrl import bbsa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [BLK_W-1:0]        i_block_number,
    input  logic [OFF_W-1:0]        i_byte_offset,
    input  logic [7:0]              i_data_byte,
    input  logic [LEN_W-1:0]        i_text_length,
    input  logic [PIX_W-1:0]        i_pointer_index,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [STAT_W-1:0]       o_status,
    output logic [VAL_W-1:0]        o_result_value,
    output t_map_req                o_map_req,
    input  logic [MAP_ROW_BITS-1:0] i_map_rdata,
    output t_store_req              o_store_req,
    input  logic [WORD_W-1:0]       i_store_rdata
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]    r_block_count;
    logic [SIZE_W-1:0]   r_block_size;
    logic [STORE_AW-1:0] r_clr, n_clr;
    logic [MAP_AW-1:0]   r_row, n_row;
    logic [WOFF_W-1:0]   r_word, n_word;

    t_cmd             r_cmd;
    logic [BLK_W-1:0] r_blk;
    logic [OFF_W-1:0] r_off;
    logic [7:0]       r_dat;
    logic [LEN_W-1:0] r_len;
    logic [PIX_W-1:0] r_pix;

    t_status           r_res_status, n_res_status;
    logic [VAL_W-1:0]  r_res_value, n_res_value;
    logic              res_load;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [VAL_W-1:0]  r_out_value;

    logic [CNT_W-1:0]        eff_cnt;
    logic [SIZE_W-1:0]       eff_size;
    logic [CNT_W-1:0]        cnt_m1;
    logic [MAP_AW-1:0]       last_row;
    logic [CNT_W-1:0]        lim;
    logic [MAP_ROW_BITS-1:0] cand;
    logic [MAP_BW-1:0]       free_idx;
    logic                    found;
    logic [SIZE_W-1:0]       size_up;
    logic [NW_W-1:0]         nwords;
    logic [NW_W-1:0]         nw_m1;
    logic [WOFF_W-1:0]       last_word;
    logic [WORD_BYTES-1:0]   zero_be;
    logic                    blk_bad;
    logic                    len_bad;
    logic                    off_bad;
    logic                    ptr_bad;
    logic                    accept;
    logic                    out_free;

    assign eff_cnt  = (r_block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : r_block_count;
    assign eff_size = (r_block_size > SIZE_W'(MAX_BLOCK_BYTES)) ?
                      SIZE_W'(MAX_BLOCK_BYTES) : r_block_size;

    assign cnt_m1   = eff_cnt - CNT_W'(1);
    assign last_row = cnt_m1[MAP_BW +: MAP_AW];
    assign lim      = eff_cnt - CNT_W'({r_row, MAP_BW'(0)});

    always_comb begin
        for (int b = 0; b < MAP_ROW_BITS; b++) begin
            cand[b] = !i_map_rdata[b] &&
                      ((lim[CNT_W-1:MAP_BW] != '0) || (lim[MAP_BW-1:0] > MAP_BW'(b)));
        end
    end

    always_comb begin
        free_idx = '0;
        for (int b = MAP_ROW_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                free_idx = MAP_BW'(b);
            end
        end
    end

    assign found = |cand;

    assign size_up   = eff_size + SIZE_W'(WORD_BYTES - 1);
    assign nwords    = size_up[SIZE_W-1:LANE_W];
    assign nw_m1     = nwords - NW_W'(1);
    assign last_word = nw_m1[WOFF_W-1:0];

    always_comb begin
        for (int j = 0; j < WORD_BYTES; j++) begin
            zero_be[WORD_BYTES-1-j] = {1'b0, r_word, LANE_W'(j)} < eff_size;
        end
    end

    assign blk_bad = {1'b0, r_blk} >= eff_cnt;
    assign len_bad = r_len > LEN_W'(eff_size);
    assign off_bad = LEN_W'(r_off) >= r_len;
    assign ptr_bad = ({1'b0, r_pix, LANE_W'(0)} + SIZE_W'(POINTER_BYTES)) > eff_size;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_ALLOC: n_state = (eff_cnt == '0) ? S_DONE : S_ALLOC_RD;
                    CMD_FREE:  n_state = blk_bad ? S_DONE : S_FREE_WR;
                    CMD_WRITE: n_state = S_DONE;
                    CMD_PTR:   n_state = (blk_bad || ptr_bad) ? S_DONE : S_PTR_CHK;
                    default:   n_state = S_DONE;
                endcase
            end
            S_ALLOC_RD:  n_state = S_ALLOC_CHK;
            S_ALLOC_CHK: n_state = (found || r_row == last_row) ? S_DONE : S_ALLOC_RD;
            S_FREE_WR:   n_state = (nwords == '0) ? S_DONE : S_ZERO;
            S_ZERO: begin
                if (r_word == last_word) begin
                    n_state = S_DONE;
                end
            end
            S_PTR_CHK: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_map_req    = '0;
        o_store_req  = '0;
        n_clr        = r_clr;
        n_row        = r_row;
        n_word       = r_word;
        res_load     = 1'b0;
        n_res_status = STAT_OK;
        n_res_value  = '0;
        case (r_state)
            S_CLEAR: begin
                o_store_req.we    = 1'b1;
                o_store_req.be    = '1;
                o_store_req.waddr = r_clr;
                o_map_req.we      = (r_clr[STORE_AW-1:MAP_AW] == '0);
                o_map_req.waddr   = r_clr[MAP_AW-1:0];
                n_clr             = r_clr + STORE_AW'(1);
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        n_row        = '0;
                        res_load     = (eff_cnt == '0);
                        n_res_status = STAT_NONE_FREE;
                    end
                    CMD_FREE: begin
                        o_map_req.re    = !blk_bad;
                        o_map_req.raddr = r_blk[BLK_W-1:MAP_BW];
                        n_word          = '0;
                        res_load        = blk_bad;
                        n_res_status    = STAT_RANGE;
                    end
                    CMD_WRITE: begin
                        res_load = 1'b1;
                        if (len_bad) begin
                            n_res_status = STAT_TOO_LONG;
                        end else if (blk_bad || off_bad) begin
                            n_res_status = STAT_RANGE;
                        end else begin
                            n_res_status      = STAT_OK;
                            o_store_req.we    = 1'b1;
                            o_store_req.be    = WORD_BYTES'(1 << (WORD_BYTES - 1))
                                                >> r_off[LANE_W-1:0];
                            o_store_req.waddr = {r_blk, r_off[OFF_W-1:LANE_W]};
                            o_store_req.wdata = {WORD_BYTES{r_dat}};
                        end
                    end
                    CMD_PTR: begin
                        o_store_req.re    = !(blk_bad || ptr_bad);
                        o_store_req.raddr = {r_blk, r_pix};
                        res_load          = blk_bad || ptr_bad;
                        n_res_status      = STAT_RANGE;
                    end
                    default: begin
                        res_load = 1'b0;
                    end
                endcase
            end
            S_ALLOC_RD: begin
                o_map_req.re    = 1'b1;
                o_map_req.raddr = r_row;
            end
            S_ALLOC_CHK: begin
                if (found) begin
                    o_map_req.we    = 1'b1;
                    o_map_req.waddr = r_row;
                    o_map_req.wdata = i_map_rdata | (MAP_ROW_BITS'(1) << free_idx);
                    res_load        = 1'b1;
                    n_res_status    = STAT_OK;
                    n_res_value     = VAL_W'({r_row, free_idx});
                end else if (r_row == last_row) begin
                    res_load     = 1'b1;
                    n_res_status = STAT_NONE_FREE;
                end else begin
                    n_row = r_row + MAP_AW'(1);
                end
            end
            S_FREE_WR: begin
                o_map_req.we    = 1'b1;
                o_map_req.waddr = r_blk[BLK_W-1:MAP_BW];
                o_map_req.wdata = i_map_rdata & ~(MAP_ROW_BITS'(1) << r_blk[MAP_BW-1:0]);
                res_load        = (nwords == '0);
                n_res_status    = STAT_OK;
            end
            S_ZERO: begin
                o_store_req.we    = 1'b1;
                o_store_req.be    = zero_be;
                o_store_req.waddr = {r_blk, r_word};
                n_word            = r_word + WOFF_W'(1);
                res_load          = (r_word == last_word);
                n_res_status      = STAT_OK;
            end
            S_PTR_CHK: begin
                res_load     = 1'b1;
                n_res_status = STAT_OK;
                n_res_value  = VAL_W'(i_store_rdata);
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_block_count <= RST_BLOCK_COUNT;
            r_block_size  <= RST_BLOCK_SIZE;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BLOCK_COUNT) begin
                    r_block_count <= i_cfg_data[CNT_W-1:0];
                end else if (i_cfg_index == CFG_BLOCK_SIZE) begin
                    r_block_size <= i_cfg_data[SIZE_W-1:0];
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_word <= n_word;
        if (accept) begin
            r_cmd <= t_cmd'(i_cmd);
            r_blk <= i_block_number;
            r_off <= i_byte_offset;
            r_dat <= i_data_byte;
            r_len <= i_text_length;
            r_pix <= i_pointer_index;
        end
        if (res_load) begin
            r_res_status <= n_res_status;
            r_res_value  <= n_res_value;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_value = r_out_value;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted word did not start execution");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC_CHK) |-> (r_row <= last_row))
        else $error("bitmap scan ran past the last row");

    a_zero_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZERO) |-> (r_word <= last_word))
        else $error("zeroing ran past the block size");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && n_state == S_IDLE) |-> (&r_clr))
        else $error("clearing pass ended early");

    a_done_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> o_out_valid)
        else $error("finished result not presented");

endmodule
